[design/bhp_pkg.sv]
// Package: shared types and constants for the bundle header parser.
package bhp_pkg;

    localparam int OFFSET_COUNT_DEF = 8;
    localparam int ADDR_W = 2;

    typedef enum logic [4:0] {
        K_HDRLEN  = 5'd4,
        K_OFF0    = 5'd5,
        K_TIME    = 5'd13,
        K_LIFE    = 5'd14,
        K_DLEN    = 5'd15,
        K_DBYTE   = 5'd16,
        K_FOFF    = 5'd17,
        K_TLEN    = 5'd18,
        K_PTYPE   = 5'd19,
        K_PFLAGS  = 5'd20,
        K_PLEN    = 5'd21,
        K_PBYTE   = 5'd22,
        K_ALIAS   = 5'd23
    } kind_t;

    typedef enum logic [1:0] {
        ERR_NONE  = 2'd0,
        ERR_RANGE = 2'd1,
        ERR_NUL   = 2'd2,
        ERR_BIG   = 2'd3
    } err_t;

    localparam logic [ADDR_W-1:0] REG_FRAG_MASK = '0;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_message;
    } in_item_t;

    typedef struct packed {
        logic [4:0]  field_kind;
        logic [63:0] field_value;
        logic [1:0]  error_code;
        logic        message_last;
    } out_item_t;

endpackage

[design/bhp_if.sv]
// Interfaces: valid/ready channels for input bytes and result items.
interface bhp_in_if;
    logic [7:0] data_byte;
    logic       start_message;
    logic       valid;
    logic       ready;
    modport source (output data_byte, output start_message, output valid, input ready);
    modport sink (input data_byte, input start_message, input valid, output ready);
endinterface

interface bhp_out_if;
    logic [4:0]  field_kind;
    logic [63:0] field_value;
    logic [1:0]  error_code;
    logic        message_last;
    logic        valid;
    logic        ready;
    modport source (output field_kind, output field_value, output error_code,
                    output message_last, output valid, input ready);
    modport sink (input field_kind, input field_value, input error_code,
                  input message_last, input valid, output ready);
endinterface

[design/bhp_queue.sv]
// Result queue: small FIFO that holds result items until the receiver takes them.
module bhp_queue
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  bhp_pkg::out_item_t    push_item [3],
    input  logic [2:0]            push_en,
    output logic [3:0]            free_slots,
    bhp_out_if.source             out_ch
);
    import bhp_pkg::*;

    localparam int DEPTH = 8;

    out_item_t     mem_reg [DEPTH];
    logic [2:0]    rd_ptr_reg, wr_ptr_reg;
    logic [3:0]    count_reg, count_next;
    logic          pop;
    logic [1:0]    n_push;
    logic [3:0]    space;

    assign pop = out_ch.valid && out_ch.ready;
    assign n_push = 2'(push_en[0]) + 2'(push_en[1]) + 2'(push_en[2]);
    assign count_next = count_reg + 4'(n_push) - 4'(pop);
    assign space = 4'(DEPTH) - count_reg;
    assign free_slots = space;

    // Write pushed items in order at the tail.
    always_ff @(posedge clk)
    begin
        if (push_en[0])
        begin
            mem_reg[wr_ptr_reg] <= push_item[0];
        end
        if (push_en[1])
        begin
            mem_reg[wr_ptr_reg + 3'(push_en[0])] <= push_item[1];
        end
        if (push_en[2])
        begin
            mem_reg[wr_ptr_reg + 3'(push_en[0]) + 3'(push_en[1])] <= push_item[2];
        end
    end

    // Advance pointers and count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_reg + 3'(pop);
            wr_ptr_reg <= wr_ptr_reg + 3'(n_push);
            count_reg  <= count_next;
        end
    end

    assign out_ch.valid        = (count_reg != 4'd0);
    assign out_ch.field_kind   = mem_reg[rd_ptr_reg].field_kind;
    assign out_ch.field_value  = mem_reg[rd_ptr_reg].field_value;
    assign out_ch.error_code   = mem_reg[rd_ptr_reg].error_code;
    assign out_ch.message_last = mem_reg[rd_ptr_reg].message_last;

endmodule

[design/bundle_header_parser.sv]
// Top level: streaming parser for the primary header and payload of a bundle.
//
// One byte enters per transfer on in_ch; start_message marks the first byte
// of a message and aborts any message in progress without a result. Each
// completed field leaves as one transfer on out_ch (kind, value, error,
// last); one byte yields at most two results (a dictionary byte or the
// dictionary length, then the alias report), which go through an
// eight-entry result queue.
// A byte is registered on acceptance and its results are decoded in the
// next cycle and written to the queue, from which they transfer in order.
// Throughput: one byte per cycle, set by the single decode pass between
// the input register and the queue; in_ch.ready drops when the queue has
// fewer than four free entries (room for the byte in the input stage and
// for the new byte).
// The APB port holds fragment_flag_mask at address 0 (reset 1); pready is
// always high and writes take effect at the access cycle.
// Reset empties the queue and returns the parser to waiting for a start.
// A stalled receiver fills the queue and then holds off the sender.
module bundle_header_parser #(
    parameter int OFFSET_COUNT = bhp_pkg::OFFSET_COUNT_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [bhp_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    bhp_in_if.sink                     in_ch,
    bhp_out_if.source                  out_ch
);
    import bhp_pkg::*;

    localparam int IDX_W = $clog2(OFFSET_COUNT);

    typedef enum logic [13:0] {
        PH_IDLE   = 14'b00000000000001,
        PH_FLAGS  = 14'b00000000000010,
        PH_HDRLEN = 14'b00000000000100,
        PH_OFFS   = 14'b00000000001000,
        PH_TIME   = 14'b00000000010000,
        PH_LIFE   = 14'b00000000100000,
        PH_DLEN   = 14'b00000001000000,
        PH_DICT   = 14'b00000010000000,
        PH_FOFF   = 14'b00000100000000,
        PH_TLEN   = 14'b00001000000000,
        PH_PTYPE  = 14'b00010000000000,
        PH_PFLAGS = 14'b00100000000000,
        PH_PLEN   = 14'b01000000000000,
        PH_PAY    = 14'b10000000000000
    } phase_t;

    // Configuration register.
    logic [7:0] frag_mask_reg;
    assign pready = 1'b1;
    assign prdata = (paddr == REG_FRAG_MASK) ? {24'd0, frag_mask_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frag_mask_reg <= 8'd1;
        end
        else if (psel && penable && pwrite && (paddr == REG_FRAG_MASK))
        begin
            frag_mask_reg <= pwdata[7:0];
        end
    end

    // Input register stage.
    logic       in_valid_reg;
    in_item_t   in_reg;
    logic [3:0] free_slots;
    logic       accept;

    // Room for this byte's results plus those of the byte in the input stage.
    assign in_ch.ready = (free_slots >= 4'd4);
    assign accept = in_ch.valid && in_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_reg.data_byte     <= in_ch.data_byte;
            in_reg.start_message <= in_ch.start_message;
        end
    end

    // Parser state.
    phase_t      phase_reg, phase_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic [63:0] acc_reg, acc_next;
    logic [15:0] offs_reg [OFFSET_COUNT];
    logic        off_we;
    logic [IDX_W-1:0] off_idx;
    logic [31:0] dlen_reg, dlen_next;
    logic [31:0] dpos_reg, dpos_next;
    logic [32:0] nul_reg, nul_next;
    logic [7:0]  hflags_reg, hflags_next;
    logic [31:0] prem_reg, prem_next;

    out_item_t   res [3];
    logic [2:0]  res_en;

    logic [7:0]  b;
    phase_t      ph;
    logic [3:0]  cnt_in;
    logic [63:0] acc_in;
    logic [32:0] nul_in;
    logic [63:0] sdnv_acc;
    logic        sdnv_ovf;
    logic        sdnv_done;
    logic [4:0]  sdnv_kind;
    logic [31:0] dpos_inc;
    logic [32:0] nul_chk;
    logic        any_range, any_nul;
    logic [1:0]  src_a, rep_a, cus_a;
    logic [15:0] off_new;
    logic        fin_dict;
    logic [31:0] dlen_fin;
    logic [15:0] ov [OFFSET_COUNT];
    logic [IDX_W-1:0] cnt_hi;

    // Offsets as seen by the dictionary check.
    always_comb
    begin
        for (int i = 0; i < OFFSET_COUNT; i++)
        begin
            ov[i] = offs_reg[i];
        end
    end

    always_comb
    begin
        b         = in_reg.data_byte;
        ph        = in_reg.start_message ? PH_FLAGS : phase_reg;
        cnt_in    = in_reg.start_message ? 4'd0 : cnt_reg;
        acc_in    = in_reg.start_message ? 64'd0 : acc_reg;
        nul_in    = in_reg.start_message ? {1'b1, 32'd0} : nul_reg;
        dpos_next = in_reg.start_message ? 32'd0 : dpos_reg;
        phase_next  = ph;
        cnt_next    = cnt_in;
        acc_next    = acc_in;
        nul_next    = nul_in;
        dlen_next   = dlen_reg;
        hflags_next = hflags_reg;
        prem_next   = prem_reg;
        off_we      = 1'b0;
        cnt_hi      = cnt_in[IDX_W:1];
        off_idx     = cnt_hi;
        off_new     = {acc_in[7:0], b};
        res_en      = 3'b000;
        fin_dict    = 1'b0;
        dlen_fin    = dlen_reg;
        for (int i = 0; i < 3; i++)
        begin
            res[i] = '{field_kind: '0, field_value: '0, error_code: ERR_NONE,
                       message_last: 1'b0};
        end
        // SDNV step shared by all variable-length fields.
        sdnv_ovf  = (acc_in[63:25] != '0);
        sdnv_acc  = {32'd0, acc_in[24:0], b[6:0]};
        sdnv_done = !b[7];
        unique case (ph)
            PH_HDRLEN: sdnv_kind = K_HDRLEN;
            PH_DLEN:   sdnv_kind = K_DLEN;
            PH_FOFF:   sdnv_kind = K_FOFF;
            PH_TLEN:   sdnv_kind = K_TLEN;
            default:   sdnv_kind = K_PLEN;
        endcase
        dpos_inc = dpos_next + 32'd1;

        unique case (ph)
            PH_FLAGS:
            begin
                if (cnt_in == 4'd1)
                begin
                    hflags_next = b;
                end
                res_en[0] = 1'b1;
                res[0].field_kind  = 5'(cnt_in);
                res[0].field_value = {56'd0, b};
                cnt_next = cnt_in + 4'd1;
                if (cnt_in == 4'd3)
                begin
                    phase_next = PH_HDRLEN;
                    cnt_next = 4'd0;
                    acc_next = 64'd0;
                end
            end
            PH_OFFS:
            begin
                acc_next = {48'd0, off_new};
                if (cnt_in[0])
                begin
                    off_we = 1'b1;
                    res_en[0] = 1'b1;
                    res[0].field_kind  = K_OFF0 + 5'(off_idx);
                    res[0].field_value = {48'd0, off_new};
                    acc_next = 64'd0;
                end
                cnt_next = cnt_in + 4'd1;
                if (cnt_in == 4'(2 * OFFSET_COUNT - 1))
                begin
                    phase_next = PH_TIME;
                    cnt_next = 4'd0;
                    acc_next = 64'd0;
                end
            end
            PH_TIME:
            begin
                acc_next = {acc_in[55:0], b};
                cnt_next = cnt_in + 4'd1;
                if (cnt_in == 4'd7)
                begin
                    res_en[0] = 1'b1;
                    res[0].field_kind  = K_TIME;
                    res[0].field_value = {acc_in[55:0], b};
                    phase_next = PH_LIFE;
                    cnt_next = 4'd0;
                    acc_next = 64'd0;
                end
            end
            PH_LIFE:
            begin
                acc_next = {32'd0, acc_in[23:0], b};
                cnt_next = cnt_in + 4'd1;
                if (cnt_in == 4'd3)
                begin
                    res_en[0] = 1'b1;
                    res[0].field_kind  = K_LIFE;
                    res[0].field_value = {32'd0, acc_in[23:0], b};
                    phase_next = PH_DLEN;
                    cnt_next = 4'd0;
                    acc_next = 64'd0;
                end
            end
            PH_DICT:
            begin
                if (b == 8'd0)
                begin
                    nul_next = {1'b0, dpos_next};
                end
                res_en[0] = 1'b1;
                res[0].field_kind  = K_DBYTE;
                res[0].field_value = {56'd0, b};
                dpos_next = dpos_inc;
                if (dpos_inc >= dlen_reg)
                begin
                    fin_dict = 1'b1;
                end
            end
            PH_PTYPE:
            begin
                res_en[0] = 1'b1;
                res[0].field_kind  = K_PTYPE;
                res[0].field_value = {56'd0, b};
                phase_next = PH_PFLAGS;
                cnt_next = 4'd0;
                acc_next = 64'd0;
            end
            PH_PFLAGS:
            begin
                res_en[0] = 1'b1;
                res[0].field_kind  = K_PFLAGS;
                res[0].field_value = {56'd0, b};
                phase_next = PH_PLEN;
                cnt_next = 4'd0;
                acc_next = 64'd0;
            end
            PH_PAY:
            begin
                prem_next = (prem_reg != 32'd0) ? prem_reg - 32'd1 : 32'd0;
                res_en[0] = 1'b1;
                res[0].field_kind   = K_PBYTE;
                res[0].field_value  = {56'd0, b};
                res[0].message_last = (prem_next == 32'd0);
                if (prem_next == 32'd0)
                begin
                    phase_next = PH_IDLE;
                end
            end
            PH_HDRLEN, PH_DLEN, PH_FOFF, PH_TLEN, PH_PLEN:
            begin
                if (sdnv_ovf)
                begin
                    phase_next = PH_IDLE;
                    res_en[0] = 1'b1;
                    res[0].field_kind   = sdnv_kind;
                    res[0].error_code   = ERR_BIG;
                    res[0].message_last = 1'b1;
                end
                else
                begin
                    acc_next = sdnv_acc;
                    if (cnt_in != 4'd15)
                    begin
                        cnt_next = cnt_in + 4'd1;
                    end
                    if (sdnv_done)
                    begin
                        res_en[0] = 1'b1;
                        res[0].field_kind  = sdnv_kind;
                        res[0].field_value = sdnv_acc;
                        cnt_next = 4'd0;
                        acc_next = 64'd0;
                        unique case (ph)
                            PH_HDRLEN: phase_next = PH_OFFS;
                            PH_FOFF:   phase_next = PH_TLEN;
                            PH_TLEN:   phase_next = PH_PTYPE;
                            PH_DLEN:
                            begin
                                dlen_next = sdnv_acc[31:0];
                                dlen_fin  = sdnv_acc[31:0];
                                dpos_next = 32'd0;
                                nul_next  = {1'b1, 32'd0};
                                if (sdnv_acc[31:0] == 32'd0)
                                begin
                                    fin_dict = 1'b1;
                                end
                                else
                                begin
                                    phase_next = PH_DICT;
                                end
                            end
                            default:
                            begin
                                prem_next = sdnv_acc[31:0];
                                if (sdnv_acc[31:0] == 32'd0)
                                begin
                                    res[0].message_last = 1'b1;
                                    phase_next = PH_IDLE;
                                end
                                else
                                begin
                                    phase_next = PH_PAY;
                                end
                            end
                        endcase
                    end
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase

        // Dictionary checks and endpoint aliasing.
        nul_chk   = nul_next;
        any_range = 1'b0;
        any_nul   = 1'b0;
        for (int i = 0; i < OFFSET_COUNT; i++)
        begin
            if ({16'd0, ov[i]} > dlen_fin)
            begin
                any_range = 1'b1;
            end
            if (nul_chk[32] || ({17'd0, ov[i]} > nul_chk))
            begin
                any_nul = 1'b1;
            end
        end
        src_a = (ov[2] == ov[0] && ov[3] == ov[1]) ? 2'd1 : 2'd0;
        if (ov[4] == ov[0] && ov[5] == ov[1])
        begin
            rep_a = 2'd1;
        end
        else if (ov[4] == ov[2] && ov[5] == ov[3])
        begin
            rep_a = 2'd2;
        end
        else
        begin
            rep_a = 2'd0;
        end
        if (ov[6] == ov[0] && ov[7] == ov[1])
        begin
            cus_a = 2'd1;
        end
        else if (ov[6] == ov[2] && ov[7] == ov[3])
        begin
            cus_a = 2'd2;
        end
        else if (ov[6] == ov[4] && ov[7] == ov[5])
        begin
            cus_a = 2'd3;
        end
        else
        begin
            cus_a = 2'd0;
        end
        if (fin_dict)
        begin
            res_en[1] = 1'b1;
            res[1].field_kind = K_ALIAS;
            if (any_range || any_nul)
            begin
                res[1].error_code   = any_range ? ERR_RANGE : ERR_NUL;
                res[1].message_last = 1'b1;
                phase_next = PH_IDLE;
            end
            else
            begin
                res[1].field_value = {58'd0, cus_a, rep_a, src_a};
                phase_next = ((hflags_next & frag_mask_reg) != 8'd0) ? PH_FOFF : PH_PTYPE;
                cnt_next = 4'd0;
                acc_next = 64'd0;
            end
        end
        // Idle bytes produce nothing.
        if (!in_valid_reg)
        begin
            res_en = 3'b000;
        end
    end

    // Offset store, written as each offset completes.
    always_ff @(posedge clk)
    begin
        if (in_valid_reg && off_we)
        begin
            offs_reg[off_idx] <= off_new;
        end
    end

    // Advance parser state on each registered byte.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            cnt_reg    <= '0;
            acc_reg    <= '0;
            dlen_reg   <= '0;
            dpos_reg   <= '0;
            nul_reg    <= {1'b1, 32'd0};
            hflags_reg <= '0;
            prem_reg   <= '0;
        end
        else if (in_valid_reg)
        begin
            phase_reg  <= phase_next;
            cnt_reg    <= cnt_next;
            acc_reg    <= acc_next;
            dlen_reg   <= dlen_next;
            dpos_reg   <= dpos_next;
            nul_reg    <= nul_next;
            hflags_reg <= hflags_next;
            prem_reg   <= prem_next;
        end
    end

    bhp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_item  (res),
        .push_en    (res_en),
        .free_slots (free_slots),
        .out_ch     (out_ch)
    );

endmodule

[design/bhp_checker.sv]
// Checker: port-level properties of the bundle header parser, bound to the top level.
module bhp_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [4:0]  out_kind,
    input logic [1:0]  out_err,
    input logic        out_last,
    input logic [63:0] out_value
);
    import bhp_pkg::*;

    // Hold a stalled result.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_value))
        else $error("result changed while stalled");

    // Errors always end the message.
    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_err != ERR_NONE |-> out_last)
        else $error("error without last");

    // Error results carry a zero value.
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_err != ERR_NONE |-> out_value == 64'd0)
        else $error("error with value");

    // Kind stays in range.
    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_kind <= K_ALIAS)
        else $error("bad kind");

    // Drive a known ready whenever a byte is offered.
    a_in_ready_known: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid |-> !$isunknown(in_ready))
        else $error("unknown input ready");

endmodule

bind bundle_header_parser bhp_checker u_bhp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_kind  (out_ch.field_kind),
    .out_err   (out_ch.error_code),
    .out_last  (out_ch.message_last),
    .out_value (out_ch.field_value)
);

[tb/tb_bundle_header_parser.sv]
// Testbench for the bundle header parser: directed and random messages checked against a predictor.
`timescale 1ns / 1ps

module tb_bundle_header_parser;
    import bhp_pkg::*;

    localparam int FLAG_KIND_LAST = 3;
    localparam int CYCLE_LIMIT = 400000;

    typedef enum logic [3:0] {
        P_IDLE, P_FLAGS, P_HDRLEN, P_OFFS, P_TIME, P_LIFE, P_DLEN, P_DICT,
        P_FOFF, P_TLEN, P_PTYPE, P_PFLAGS, P_PLEN, P_PAY
    } phase_t;

    typedef struct packed {
        logic [4:0]  field_kind;
        logic [63:0] field_value;
        logic [1:0]  error_code;
        logic        message_last;
    } field_rec_t;

    // Predictor of the parser and queue of expected fields
    class field_scoreboard;
        logic [7:0]  frag_mask;
        phase_t      phase;
        logic [3:0]  byte_cnt;
        logic [63:0] acc;
        logic [15:0] offs [8];
        logic [31:0] dict_len;
        logic [31:0] dict_pos;
        logic [32:0] nul_pos;
        logic        nul_seen;
        logic [7:0]  hdr_flags;
        logic [31:0] pay_left;
        field_rec_t  pending [$];
        int          errors;

        function new();
            frag_mask = 8'd1;
            phase = P_IDLE;
            byte_cnt = '0;
            acc = '0;
            dict_len = '0;
            dict_pos = '0;
            nul_pos = '0;
            nul_seen = 1'b0;
            hdr_flags = '0;
            pay_left = '0;
            errors = 0;
            foreach (offs[i]) offs[i] = '0;
        endfunction

        function void push(logic [4:0] k, logic [63:0] v, err_t e, logic l);
            field_rec_t r;
            r.field_kind = k;
            r.field_value = v;
            r.error_code = e;
            r.message_last = l;
            pending.push_back(r);
        endfunction

        function void next_field(phase_t p);
            phase = p;
            byte_cnt = '0;
            acc = '0;
        endfunction

        function void check_dictionary();
            logic [1:0] src, rep, cus;
            for (int i = 0; i < 8; i++)
                if ({16'd0, offs[i]} > dict_len)
                begin
                    phase = P_IDLE;
                    push(K_ALIAS, '0, ERR_RANGE, 1'b1);
                    return;
                end
            for (int i = 0; i < 8; i++)
                if (!nul_seen || {17'd0, offs[i]} > nul_pos)
                begin
                    phase = P_IDLE;
                    push(K_ALIAS, '0, ERR_NUL, 1'b1);
                    return;
                end
            src = (offs[2] == offs[0] && offs[3] == offs[1]) ? 2'd1 : 2'd0;
            if (offs[4] == offs[0] && offs[5] == offs[1]) rep = 2'd1;
            else if (offs[4] == offs[2] && offs[5] == offs[3]) rep = 2'd2;
            else rep = 2'd0;
            if (offs[6] == offs[0] && offs[7] == offs[1]) cus = 2'd1;
            else if (offs[6] == offs[2] && offs[7] == offs[3]) cus = 2'd2;
            else if (offs[6] == offs[4] && offs[7] == offs[5]) cus = 2'd3;
            else cus = 2'd0;
            push(K_ALIAS, {58'd0, cus, rep, src}, ERR_NONE, 1'b0);
            next_field((hdr_flags & frag_mask) != 0 ? P_FOFF : P_PTYPE);
        endfunction

        // Note one accepted byte and queue the fields it completes
        function void note_byte(logic [7:0] b, logic start);
            logic [4:0]  k;
            logic [31:0] v;
            int          idx;
            if (start)
            begin
                next_field(P_FLAGS);
                dict_pos = '0;
                nul_seen = 1'b0;
            end
            case (phase)
                P_FLAGS:
                begin
                    if (byte_cnt == 1) hdr_flags = b;
                    push(5'(byte_cnt), {56'd0, b}, ERR_NONE, 1'b0);
                    byte_cnt++;
                    if (byte_cnt > FLAG_KIND_LAST) next_field(P_HDRLEN);
                end
                P_OFFS:
                begin
                    acc = {48'd0, acc[7:0], b};
                    if (byte_cnt[0])
                    begin
                        idx = byte_cnt[3:1];
                        offs[idx] = acc[15:0];
                        push(5'(K_OFF0 + idx), acc, ERR_NONE, 1'b0);
                        acc = '0;
                    end
                    byte_cnt++;
                    if (byte_cnt == 0) next_field(P_TIME);
                end
                P_TIME:
                begin
                    acc = {acc[55:0], b};
                    byte_cnt++;
                    if (byte_cnt >= 8)
                    begin
                        push(K_TIME, acc, ERR_NONE, 1'b0);
                        next_field(P_LIFE);
                    end
                end
                P_LIFE:
                begin
                    acc = {32'd0, acc[23:0], b};
                    byte_cnt++;
                    if (byte_cnt >= 4)
                    begin
                        push(K_LIFE, acc, ERR_NONE, 1'b0);
                        next_field(P_DLEN);
                    end
                end
                P_DICT:
                begin
                    if (b == 0)
                    begin
                        nul_pos = {1'b0, dict_pos};
                        nul_seen = 1'b1;
                    end
                    push(K_DBYTE, {56'd0, b}, ERR_NONE, 1'b0);
                    dict_pos++;
                    if (dict_pos >= dict_len) check_dictionary();
                end
                P_PTYPE:
                begin
                    push(K_PTYPE, {56'd0, b}, ERR_NONE, 1'b0);
                    next_field(P_PFLAGS);
                end
                P_PFLAGS:
                begin
                    push(K_PFLAGS, {56'd0, b}, ERR_NONE, 1'b0);
                    next_field(P_PLEN);
                end
                P_PAY:
                begin
                    if (pay_left > 0) pay_left--;
                    push(K_PBYTE, {56'd0, b}, ERR_NONE, pay_left == 0);
                    if (pay_left == 0) phase = P_IDLE;
                end
                P_HDRLEN, P_DLEN, P_FOFF, P_TLEN, P_PLEN:
                begin
                    case (phase)
                        P_HDRLEN: k = K_HDRLEN;
                        P_DLEN:   k = K_DLEN;
                        P_FOFF:   k = K_FOFF;
                        P_TLEN:   k = K_TLEN;
                        default:  k = K_PLEN;
                    endcase
                    if (acc[63:25] != 0)
                    begin
                        phase = P_IDLE;
                        push(k, '0, ERR_BIG, 1'b1);
                    end
                    else
                    begin
                        acc = {32'd0, acc[24:0], b[6:0]};
                        if (byte_cnt < 15) byte_cnt++;
                        if (!b[7])
                        begin
                            v = acc[31:0];
                            case (phase)
                                P_HDRLEN:
                                begin
                                    push(k, {32'd0, v}, ERR_NONE, 1'b0);
                                    next_field(P_OFFS);
                                end
                                P_DLEN:
                                begin
                                    dict_len = v;
                                    dict_pos = '0;
                                    nul_seen = 1'b0;
                                    push(k, {32'd0, v}, ERR_NONE, 1'b0);
                                    if (v == 0) check_dictionary();
                                    else next_field(P_DICT);
                                end
                                P_FOFF:
                                begin
                                    push(k, {32'd0, v}, ERR_NONE, 1'b0);
                                    next_field(P_TLEN);
                                end
                                P_TLEN:
                                begin
                                    push(k, {32'd0, v}, ERR_NONE, 1'b0);
                                    next_field(P_PTYPE);
                                end
                                default:
                                begin
                                    pay_left = v;
                                    push(k, {32'd0, v}, ERR_NONE, v == 0);
                                    if (v == 0) phase = P_IDLE;
                                    else next_field(P_PAY);
                                end
                            endcase
                        end
                    end
                end
                default: phase = P_IDLE;
            endcase
        endfunction

        // Compare one received field with the oldest expectation
        function void check_field(field_rec_t got);
            field_rec_t want;
            if (pending.size() == 0)
            begin
                $error("unexpected field kind=%0d value=%0h", got.field_kind, got.field_value);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.field_kind !== want.field_kind)
            begin
                $error("field_kind: expected %0d, got %0d", want.field_kind, got.field_kind);
                errors++;
            end
            if (got.field_value !== want.field_value)
            begin
                $error("field_value: expected %0h, got %0h", want.field_value, got.field_value);
                errors++;
            end
            if (got.error_code !== want.error_code)
            begin
                $error("error_code: expected %0d, got %0d", want.error_code, got.error_code);
                errors++;
            end
            if (got.message_last !== want.message_last)
            begin
                $error("message_last: expected %0d, got %0d", want.message_last,
                       got.message_last);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;
    bhp_in_if in_ch ();
    bhp_out_if out_ch ();

    field_scoreboard sb;
    logic [7:0] msg [$];
    logic stim_done;
    logic hold_req;
    logic long_hold;
    int   cycle_count;

    bundle_header_parser u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .in_ch   (in_ch),
        .out_ch  (out_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Send one byte; keep valid high in a burst, drop it for a random gap
    task automatic send_byte(input logic [7:0] b, input logic start);
        if ($urandom_range(0, 7) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        in_ch.data_byte <= b;
        in_ch.start_message <= start;
        in_ch.valid <= 1'b1;
        @(posedge clk iff in_ch.ready);
        sb.note_byte(b, start);
    endtask

    task automatic send_message();
        for (int i = 0; i < msg.size(); i++) send_byte(msg[i], i == 0);
    endtask

    // Append an SDNV encoding of v
    task automatic add_sdnv(input logic [31:0] v);
        logic [6:0] grp [$];
        logic [31:0] t;
        t = v;
        do
        begin
            grp.push_front(t[6:0]);
            t = t >> 7;
        end
        while (t != 0);
        foreach (grp[i]) msg.push_back({i != grp.size() - 1, grp[i]});
    endtask

    // Build a message; the mode picks a clean or a damaged layout
    task automatic build_message(input logic frag, input int dlen, input int plen,
                                 input int damage);
        logic [15:0] o [8];
        logic [7:0] flags1;
        int nulp;
        msg.delete();
        flags1 = 8'($urandom);
        flags1 = frag ? (flags1 | sb.frag_mask) : (flags1 & ~sb.frag_mask);
        msg.push_back(8'($urandom));
        msg.push_back(flags1);
        msg.push_back(8'($urandom));
        msg.push_back(8'($urandom));
        add_sdnv($urandom_range(0, 300));
        nulp = (dlen > 0) ? int'($urandom_range(0, dlen - 1)) : 0;
        for (int i = 0; i < 8; i++)
        begin
            case ($urandom_range(0, 3))
                0: o[i] = (i >= 2) ? o[i - 2] : 16'(0);
                1: o[i] = (i >= 4) ? o[i - 4] : 16'(0);
                default: o[i] = 16'($urandom_range(0, nulp));
            endcase
            if (o[i] > nulp) o[i] = 16'(nulp);
        end
        if (damage == 1) o[$urandom_range(0, 7)] = 16'($urandom);
        if (damage == 2) o[$urandom_range(0, 7)] = 16'(dlen);
        foreach (o[i])
        begin
            msg.push_back(o[i][15:8]);
            msg.push_back(o[i][7:0]);
        end
        repeat (12) msg.push_back(8'($urandom));
        add_sdnv(dlen);
        for (int i = 0; i < dlen; i++)
            msg.push_back(i == nulp ? 8'd0 : 8'($urandom_range(1, 255)));
        if (frag)
        begin
            add_sdnv($urandom);
            add_sdnv($urandom);
        end
        msg.push_back(8'($urandom));
        msg.push_back(8'($urandom));
        if (damage == 3)
        begin
            repeat (5) msg.push_back(8'hFF);
            return;
        end
        add_sdnv(plen);
        for (int i = 0; i < plen; i++) msg.push_back(8'($urandom));
        if (damage == 4) msg = msg[0:$urandom_range(1, msg.size() - 1)];
    endtask

    // Register write during idle: setup then access
    task automatic write_mask(input logic [7:0] v);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= REG_FRAG_MASK;
        pwdata <= {24'd0, v};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        sb.frag_mask = v;
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Sender
    initial
    begin
        int count;
        logic [7:0] mask_set [4];
        sb = new();
        mask_set = '{8'hFF, 8'h00, 8'h80, 8'h01};
        stim_done = 1'b0;
        hold_req = 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        in_ch.valid <= 1'b0;
        in_ch.data_byte <= '0;
        in_ch.start_message <= 1'b0;
        rst_n <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: stray bytes, empty dictionary, empty payload, a fragmented message, oversize SDNV
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        build_message(1'b0, 0, 0, 0);
        send_message();
        build_message(1'b1, 3, 1, 0);
        send_message();
        build_message(1'b0, 2, 2, 3);
        send_message();
        drain();

        count = 0;
        for (int phase_i = 0; phase_i < 4; phase_i++)
        begin
            write_mask(mask_set[phase_i]);
            if (phase_i == 1) hold_req = 1'b1;
            while (count < (phase_i + 1) * 120)
            begin
                build_message(1'($urandom_range(0, 1)), $urandom_range(0, 6),
                              $urandom_range(0, 5),
                              $urandom_range(0, 9) < 6 ? 0 : $urandom_range(1, 4));
                count += msg.size();
                send_message();
                if ($urandom_range(0, 5) == 0)
                begin
                    send_byte(8'($urandom), 1'b0);
                    count++;
                end
            end
            drain();
        end
        stim_done = 1'b1;
    end

    // Long hold-off of the receiver, counted here in cycles
    initial
    begin
        int hold;
        long_hold <= 1'b0;
        @(posedge clk);
        while (!hold_req) @(posedge clk);
        long_hold <= 1'b1;
        hold = 0;
        while (hold < 200)
        begin
            @(posedge clk);
            hold++;
        end
        long_hold <= 1'b0;
    end

    // Receiver: its own stall pattern, held off during the long hold
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else if (long_hold)
            out_ch.ready <= 1'b0;
        else if ((cycle_count / 64) % 3 == 0)
            out_ch.ready <= 1'b1;
        else
            out_ch.ready <= ($urandom_range(0, 3) != 0);
    end

    // Check every result transfer
    always @(posedge clk)
    begin
        field_rec_t got;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got.field_kind = out_ch.field_kind;
            got.field_value = out_ch.field_value;
            got.error_code = out_ch.error_code;
            got.message_last = out_ch.message_last;
            sb.check_field(got);
        end
    end

    // End of run and timeout
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (stim_done)
            begin
                if (sb.errors == 0 && sb.pending.size() == 0)
                    $display("tb_bundle_header_parser: PASS");
                else
                    $display("tb_bundle_header_parser: FAIL");
                $finish;
            end
            else if (cycle_count > CYCLE_LIMIT)
            begin
                $display("tb_bundle_header_parser: FAIL");
                $finish;
            end
        end
    end

endmodule
